>>> src/bdpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants for the button debounce classifier
// Beat structs, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int TIME_IN_W  = 32;
  localparam int LEVEL_BITS = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int EVENT_CAP  = 16;
  localparam int EV_CNT_W   = 5;
  localparam int BTN_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 8'd1;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd30;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic [TIME_IN_W-1:0]  time_now;
    logic [LEVEL_BITS-1:0] button_levels;
  } bdpc_in_t;

  typedef struct packed {
    logic [BTN_IDX_W-1:0] button_index;
    logic                 long_press;
    logic                 last_event;
  } bdpc_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EDGE,
    S_HOLD,
    S_EMIT
  } bdpc_state_t;

endpackage
`default_nettype wire

>>> src/button_debounce_press_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence: an edge check for each button, a held-time check for each accepted
//   release, then an emit step for each event and a final step to leave the
//   emit phase. While out_stall holds a pending beat, the emit phase waits.
// Throughput: one scan at a time; the next scan is taken once the emit phase
//   ends and the block is idle again.
// Reset: levels idle, edge and press times zero, thresholds 30 and 1000 ms.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a bank of active-low buttons and classifies releases as short or
// long presses, one shared subtractor walked over the buttons.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int NUM_BUTTONS = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // scan input
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire bdpc_in_t              in_data,
  // press events
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output bdpc_out_t                  out_data,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  bdpc_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIME_BITS-1:0]   now_r;
  logic [LEVEL_BITS-1:0]  levels_r;
  logic [CFG_DATA_W-1:0]  deb_r, long_r;

  // per-button state, each written only at the walk position
  logic [NUM_BUTTONS-1:0] stable_r;
  logic [TIME_BITS-1:0]   last_edge_r   [NUM_BUTTONS];
  logic [TIME_BITS-1:0]   press_start_r [NUM_BUTTONS];

  // event list built during the walk, drained in button order
  logic [NUM_BUTTONS-1:0] ev_mask_r, ev_mask_nxt;
  logic [NUM_BUTTONS-1:0] ev_long_r, ev_long_nxt;
  logic [EV_CNT_W-1:0]    ev_cnt_r, ev_cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  bdpc_out_t              out_r, out_nxt;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_take;
  logic cfg_take;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // scan time, zero-extended or truncated to the wrap width
  logic [TIME_BITS+TIME_IN_W-1:0] now_full;
  assign now_full = {{TIME_BITS{1'b0}}, in_data.time_now};

  // levels per button; buttons past the level field read as pressed
  logic [NUM_BUTTONS-1:0] lvl_vec;
  always_comb begin
    for (int j = 0; j < NUM_BUTTONS; j++) begin
      lvl_vec[j] = (j < LEVEL_BITS) ? levels_r[j % LEVEL_BITS] : 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared subtract / compare unit
  // EDGE uses the last edge time, HOLD the press start time.
  // --------------------------------------------------------------------------
  logic [TIME_BITS+CFG_DATA_W-1:0] deb_full, long_full;
  logic [TIME_BITS-1:0]            deb_ext, long_ext;
  logic [TIME_BITS-1:0]            operand;
  logic [TIME_BITS-1:0]            diff;
  logic                            ge_deb, ge_long;
  logic                            cur_level;

  assign deb_full  = {{TIME_BITS{1'b0}}, deb_r};
  assign long_full = {{TIME_BITS{1'b0}}, long_r};
  assign deb_ext   = deb_full[TIME_BITS-1:0];
  assign long_ext  = long_full[TIME_BITS-1:0];

  assign cur_level = lvl_vec[idx_r];
  assign operand   = (state_r == S_HOLD) ? press_start_r[idx_r] : last_edge_r[idx_r];
  assign diff      = now_r - operand;     // wraps modulo 2^TIME_BITS
  assign ge_deb    = (diff >= deb_ext);
  assign ge_long   = (diff >= long_ext);

  logic edge_take;
  assign edge_take = (state_r == S_EDGE) && (cur_level != stable_r[idx_r]) && ge_deb;

  // --------------------------------------------------------------------------
  // Emit side: lowest pending button first
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]            sel;
  logic [NUM_BUTTONS-1:0]      mask_rest;
  logic [IDX_W+BTN_IDX_W-1:0]  sel_full;
  logic                        slot_free;
  logic                        load;

  always_comb begin
    sel = '0;
    for (int j = NUM_BUTTONS - 1; j >= 0; j--) begin
      if (ev_mask_r[j]) begin
        sel = IDX_W'(j);
      end
    end
    mask_rest      = ev_mask_r;
    mask_rest[sel] = 1'b0;
  end

  assign sel_full  = {{BTN_IDX_W{1'b0}}, sel};
  assign slot_free = !out_valid_r || !out_stall;
  assign load      = (state_r == S_EMIT) && (ev_mask_r != '0) && slot_free;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    ev_mask_nxt   = ev_mask_r;
    ev_long_nxt   = ev_long_r;
    ev_cnt_nxt    = ev_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt   = S_EDGE;
          idx_nxt     = '0;
          ev_mask_nxt = '0;
          ev_long_nxt = '0;
          ev_cnt_nxt  = '0;
        end
      end
      S_EDGE: begin
        if (edge_take && cur_level) begin
          state_nxt = S_HOLD;          // release: measure the held time
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_HOLD: begin
        // long flag taken from ge_long alone, so it wins when the thresholds cross
        if ((ge_long || ge_deb) && (ev_cnt_r < EV_CNT_W'(EVENT_CAP))) begin
          ev_mask_nxt[idx_r] = 1'b1;
          ev_long_nxt[idx_r] = ge_long;
          ev_cnt_nxt         = ev_cnt_r + EV_CNT_W'(1);
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_EDGE;
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (ev_mask_r == '0) begin
          state_nxt = S_IDLE;
        end else if (load) begin
          out_valid_nxt        = 1'b1;
          out_nxt.button_index = sel_full[BTN_IDX_W-1:0];
          out_nxt.long_press   = ev_long_r[sel];
          out_nxt.last_event   = (mask_rest == '0);
          ev_mask_nxt          = mask_rest;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      ev_mask_r   <= '0;
      ev_long_r   <= '0;
      ev_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      ev_mask_r   <= ev_mask_nxt;
      ev_long_r   <= ev_long_nxt;
      ev_cnt_r    <= ev_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_take) begin
      now_r    <= now_full[TIME_BITS-1:0];
      levels_r <= in_data.button_levels;
    end
  end

  // thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEBOUNCE_RST;
      long_r <= LONG_PRESS_RST;
    end else if (cfg_take) begin
      case (cfg_index)
        REG_DEBOUNCE:   deb_r  <= cfg_data;
        REG_LONG_PRESS: long_r <= cfg_data;
        default: ;                     // unknown index: ignored
      endcase
    end
  end

  // per-button debounce state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= '1;
      for (int j = 0; j < NUM_BUTTONS; j++) begin
        last_edge_r[j]   <= '0;
        press_start_r[j] <= '0;
      end
    end else if (edge_take) begin
      stable_r[idx_r]    <= cur_level;
      last_edge_r[idx_r] <= now_r;
      if (!cur_level) begin
        press_start_r[idx_r] <= now_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_hold_after_edge: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> $past(state_r) == S_EDGE)
    else $error("held-time check without a preceding edge check");

  a_event_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= EV_CNT_W'(EVENT_CAP))
    else $error("event count past cap");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (ev_mask_r == '0))
    else $error("pending events left while idle");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_nxt.last_event) |=> (ev_mask_r == '0))
    else $error("last event marked with events still pending");

endmodule
`default_nettype wire
